// ===== src/rfpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rfpt_pkg;

   // Number format of the stored elements and of the arithmetic.
   localparam int WORD_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int PROD_W    = 2 * WORD_W;

   // Fixed field widths of the two channels.
   localparam int IN_VAL_W  = 32;
   localparam int OUT_VAL_W = 32;
   localparam int IDX_W     = 6;
   localparam int RES_IDX_W = 5;

   localparam int NUM_ELEM  = 36;
   localparam int NUM_RES   = 18;
   localparam int ELEM_AW   = $clog2(NUM_ELEM);

   localparam int NUM_SCR   = 6;
   localparam int SCR_W     = $clog2(NUM_SCR);

   localparam int UPC_W     = 7;
   localparam int UPC_LAST  = 83;

   // Opcodes of the input channel.
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   // Datapath operation selected by a microcode word.
   localparam logic OP_PASS = 1'b0;
   localparam logic OP_MUL  = 1'b1;

   // How the stage-two value is merged with the accumulator.
   localparam logic [1:0] ACC_LOAD = 2'd0;
   localparam logic [1:0] ACC_ADD  = 2'd1;
   localparam logic [1:0] ACC_SUB  = 2'd2;

   // Base addresses of the element groups in the store.
   localparam int E_RF = 0;
   localparam int E_TF = 9;
   localparam int E_RG = 12;
   localparam int E_TG = 21;
   localparam int E_VF = 24;
   localparam int E_WF = 27;
   localparam int E_VG = 30;
   localparam int E_WG = 33;

   // Scratch registers: a column vector x and the offset d.
   localparam int S_X0 = 0;
   localparam int S_X1 = 1;
   localparam int S_X2 = 2;
   localparam int S_D0 = 3;
   localparam int S_D1 = 4;
   localparam int S_D2 = 5;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef struct packed {
      logic                        opcode;
      logic [IDX_W-1:0]            element_index;
      logic signed [IN_VAL_W-1:0]  element_value;
   } req_type;

   typedef struct packed {
      logic [RES_IDX_W-1:0]        result_index;
      logic signed [OUT_VAL_W-1:0] result_value;
      logic                        last;
   } rsp_type;

   typedef struct packed {
      logic               op;
      logic               b_scr;
      logic [SCR_W-1:0]   scr;
      logic [1:0]         mode;
      logic               wr_scr;
      logic               emit;
      logic               halt;
      logic [ELEM_AW-1:0] addr_a;
      logic [ELEM_AW-1:0] addr_b;
   } ucode_type;

   function automatic word_type sat_add(word_type a, word_type b);
      logic [WORD_W:0] s;
      s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) begin
         return s[WORD_W] ? WORD_MIN : WORD_MAX;
      end
      return s[WORD_W-1:0];
   endfunction

   function automatic word_type sat_sub(word_type a, word_type b);
      logic [WORD_W:0] s;
      s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) begin
         return s[WORD_W] ? WORD_MIN : WORD_MAX;
      end
      return s[WORD_W-1:0];
   endfunction

   // Arithmetic shift of the full product, then clamp to the word range.
   function automatic word_type sat_prod(prod_type p);
      prod_type        sh;
      logic [WORD_W:0] hi;
      sh = p >>> FRAC_BITS;
      hi = sh[PROD_W-1:WORD_W-1];
      if ((&hi) || (~|hi)) begin
         return sh[WORD_W-1:0];
      end
      return sh[PROD_W-1] ? WORD_MIN : WORD_MAX;
   endfunction

   function automatic word_type load_word(logic signed [IN_VAL_W-1:0] v);
      logic signed [64:0] vx;
      logic signed [64:0] mx;
      logic signed [64:0] mn;
      vx = 65'(v);
      mx = 65'(WORD_MAX);
      mn = 65'(WORD_MIN);
      if (vx > mx) begin
         return WORD_MAX;
      end
      if (vx < mn) begin
         return WORD_MIN;
      end
      return WORD_W'(vx);
   endfunction

   function automatic ucode_type uw(logic op, logic b_scr, int a, int b, int s,
                                    logic [1:0] mode, logic wr, logic emit);
      ucode_type w;
      w.op     = op;
      w.b_scr  = b_scr;
      w.scr    = SCR_W'(s);
      w.mode   = mode;
      w.wr_scr = wr;
      w.emit   = emit;
      w.halt   = 1'b0;
      w.addr_a = ELEM_AW'(a);
      w.addr_b = ELEM_AW'(b);
      return w;
   endfunction

   // Product of two store elements.
   function automatic ucode_type mm(int a, int b, logic [1:0] mode, logic emit);
      return uw(OP_MUL, 1'b0, a, b, 0, mode, 1'b0, emit);
   endfunction

   // Product of a store element and a scratch register.
   function automatic ucode_type ms(int a, int s, logic [1:0] mode, logic emit);
      return uw(OP_MUL, 1'b1, a, 0, s, mode, 1'b0, emit);
   endfunction

   // Store element passed straight to the accumulator stage.
   function automatic ucode_type ps(int a, logic [1:0] mode, logic wr, int s);
      return uw(OP_PASS, 1'b0, a, 0, s, mode, wr, 1'b0);
   endfunction

   // The microprogram. A scratch register written by one step is read no
   // earlier than two steps later, which covers the datapath latency.
   function automatic ucode_type ucode_word(logic [UPC_W-1:0] pc);
      ucode_type w;
      case (pc)
         // Local rotation, row-major: Rf^T times each column of Rg.
         0:  w = mm(E_RF+0, E_RG+0, ACC_LOAD, 1'b0);
         1:  w = mm(E_RF+3, E_RG+3, ACC_ADD,  1'b0);
         2:  w = mm(E_RF+6, E_RG+6, ACC_ADD,  1'b1);
         3:  w = mm(E_RF+0, E_RG+1, ACC_LOAD, 1'b0);
         4:  w = mm(E_RF+3, E_RG+4, ACC_ADD,  1'b0);
         5:  w = mm(E_RF+6, E_RG+7, ACC_ADD,  1'b1);
         6:  w = mm(E_RF+0, E_RG+2, ACC_LOAD, 1'b0);
         7:  w = mm(E_RF+3, E_RG+5, ACC_ADD,  1'b0);
         8:  w = mm(E_RF+6, E_RG+8, ACC_ADD,  1'b1);
         9:  w = mm(E_RF+1, E_RG+0, ACC_LOAD, 1'b0);
         10: w = mm(E_RF+4, E_RG+3, ACC_ADD,  1'b0);
         11: w = mm(E_RF+7, E_RG+6, ACC_ADD,  1'b1);
         12: w = mm(E_RF+1, E_RG+1, ACC_LOAD, 1'b0);
         13: w = mm(E_RF+4, E_RG+4, ACC_ADD,  1'b0);
         14: w = mm(E_RF+7, E_RG+7, ACC_ADD,  1'b1);
         15: w = mm(E_RF+1, E_RG+2, ACC_LOAD, 1'b0);
         16: w = mm(E_RF+4, E_RG+5, ACC_ADD,  1'b0);
         17: w = mm(E_RF+7, E_RG+8, ACC_ADD,  1'b1);
         18: w = mm(E_RF+2, E_RG+0, ACC_LOAD, 1'b0);
         19: w = mm(E_RF+5, E_RG+3, ACC_ADD,  1'b0);
         20: w = mm(E_RF+8, E_RG+6, ACC_ADD,  1'b1);
         21: w = mm(E_RF+2, E_RG+1, ACC_LOAD, 1'b0);
         22: w = mm(E_RF+5, E_RG+4, ACC_ADD,  1'b0);
         23: w = mm(E_RF+8, E_RG+7, ACC_ADD,  1'b1);
         24: w = mm(E_RF+2, E_RG+2, ACC_LOAD, 1'b0);
         25: w = mm(E_RF+5, E_RG+5, ACC_ADD,  1'b0);
         26: w = mm(E_RF+8, E_RG+8, ACC_ADD,  1'b1);
         // Local translation: x = tg - tf, then Rf^T x.
         27: w = ps(E_TG+0, ACC_LOAD, 1'b0, S_X0);
         28: w = ps(E_TF+0, ACC_SUB,  1'b1, S_X0);
         29: w = ps(E_TG+1, ACC_LOAD, 1'b0, S_X1);
         30: w = ps(E_TF+1, ACC_SUB,  1'b1, S_X1);
         31: w = ps(E_TG+2, ACC_LOAD, 1'b0, S_X2);
         32: w = ps(E_TF+2, ACC_SUB,  1'b1, S_X2);
         33: w = ms(E_RF+0, S_X0, ACC_LOAD, 1'b0);
         34: w = ms(E_RF+3, S_X1, ACC_ADD,  1'b0);
         35: w = ms(E_RF+6, S_X2, ACC_ADD,  1'b1);
         36: w = ms(E_RF+1, S_X0, ACC_LOAD, 1'b0);
         37: w = ms(E_RF+4, S_X1, ACC_ADD,  1'b0);
         38: w = ms(E_RF+7, S_X2, ACC_ADD,  1'b1);
         39: w = ms(E_RF+2, S_X0, ACC_LOAD, 1'b0);
         40: w = ms(E_RF+5, S_X1, ACC_ADD,  1'b0);
         41: w = ms(E_RF+8, S_X2, ACC_ADD,  1'b1);
         // Linear twist: d = tf - tg, x = (wf cross d + vg) - vf, then Rf^T x.
         42: w = ps(E_TF+0, ACC_LOAD, 1'b0, S_D0);
         43: w = ps(E_TG+0, ACC_SUB,  1'b1, S_D0);
         44: w = ps(E_TF+1, ACC_LOAD, 1'b0, S_D1);
         45: w = ps(E_TG+1, ACC_SUB,  1'b1, S_D1);
         46: w = ps(E_TF+2, ACC_LOAD, 1'b0, S_D2);
         47: w = ps(E_TG+2, ACC_SUB,  1'b1, S_D2);
         48: w = ms(E_WF+0, S_D1, ACC_LOAD, 1'b0);
         49: w = ms(E_WF+1, S_D0, ACC_SUB,  1'b0);
         50: w = ps(E_VG+2, ACC_ADD, 1'b0, S_X2);
         51: w = ps(E_VF+2, ACC_SUB, 1'b1, S_X2);
         52: w = ms(E_WF+1, S_D2, ACC_LOAD, 1'b0);
         53: w = ms(E_WF+2, S_D1, ACC_SUB,  1'b0);
         54: w = ps(E_VG+0, ACC_ADD, 1'b0, S_X0);
         55: w = ps(E_VF+0, ACC_SUB, 1'b1, S_X0);
         56: w = ms(E_WF+2, S_D0, ACC_LOAD, 1'b0);
         57: w = ms(E_WF+0, S_D2, ACC_SUB,  1'b0);
         58: w = ps(E_VG+1, ACC_ADD, 1'b0, S_X1);
         59: w = ps(E_VF+1, ACC_SUB, 1'b1, S_X1);
         60: w = ms(E_RF+0, S_X0, ACC_LOAD, 1'b0);
         61: w = ms(E_RF+3, S_X1, ACC_ADD,  1'b0);
         62: w = ms(E_RF+6, S_X2, ACC_ADD,  1'b1);
         63: w = ms(E_RF+1, S_X0, ACC_LOAD, 1'b0);
         64: w = ms(E_RF+4, S_X1, ACC_ADD,  1'b0);
         65: w = ms(E_RF+7, S_X2, ACC_ADD,  1'b1);
         66: w = ms(E_RF+2, S_X0, ACC_LOAD, 1'b0);
         67: w = ms(E_RF+5, S_X1, ACC_ADD,  1'b0);
         68: w = ms(E_RF+8, S_X2, ACC_ADD,  1'b1);
         // Angular twist: x = wg - wf, then Rf^T x.
         69: w = ps(E_WG+0, ACC_LOAD, 1'b0, S_X0);
         70: w = ps(E_WF+0, ACC_SUB,  1'b1, S_X0);
         71: w = ps(E_WG+1, ACC_LOAD, 1'b0, S_X1);
         72: w = ps(E_WF+1, ACC_SUB,  1'b1, S_X1);
         73: w = ps(E_WG+2, ACC_LOAD, 1'b0, S_X2);
         74: w = ps(E_WF+2, ACC_SUB,  1'b1, S_X2);
         75: w = ms(E_RF+0, S_X0, ACC_LOAD, 1'b0);
         76: w = ms(E_RF+3, S_X1, ACC_ADD,  1'b0);
         77: w = ms(E_RF+6, S_X2, ACC_ADD,  1'b1);
         78: w = ms(E_RF+1, S_X0, ACC_LOAD, 1'b0);
         79: w = ms(E_RF+4, S_X1, ACC_ADD,  1'b0);
         80: w = ms(E_RF+7, S_X2, ACC_ADD,  1'b1);
         81: w = ms(E_RF+2, S_X0, ACC_LOAD, 1'b0);
         82: w = ms(E_RF+5, S_X1, ACC_ADD,  1'b0);
         83: w = ms(E_RF+8, S_X2, ACC_ADD,  1'b1);
         default: w = ps(E_RF, ACC_LOAD, 1'b0, S_X0);
      endcase
      if ((pc == UPC_W'(UPC_LAST)) || (pc > UPC_W'(UPC_LAST))) begin
         w.halt = 1'b1;
      end
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== src/rfpt_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rfpt_store (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          wr_en,
   input  wire logic [rfpt_pkg::ELEM_AW-1:0]  wr_addr,
   input  wire rfpt_pkg::word_type            wr_data,
   input  wire logic                          rd_en,
   input  wire logic [rfpt_pkg::ELEM_AW-1:0]  rd_addr_a,
   input  wire logic [rfpt_pkg::ELEM_AW-1:0]  rd_addr_b,
   output rfpt_pkg::word_type                 rd_data_a,
   output rfpt_pkg::word_type                 rd_data_b
);
   import rfpt_pkg::*;

   word_type            mem [NUM_ELEM];
   logic [NUM_ELEM-1:0] vld_ff;
   logic [NUM_ELEM-1:0] vld_in;
   word_type            dat_a_ff;
   word_type            dat_b_ff;
   logic                hit_a_ff;
   logic                hit_b_ff;

   // An entry never written since reset reads as zero.
   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         dat_a_ff <= mem[rd_addr_a];
         dat_b_ff <= mem[rd_addr_b];
         hit_a_ff <= vld_ff[rd_addr_a];
         hit_b_ff <= vld_ff[rd_addr_b];
      end
   end

   assign rd_data_a = hit_a_ff ? dat_a_ff : '0;
   assign rd_data_b = hit_b_ff ? dat_b_ff : '0;

endmodule

`default_nettype wire

// ===== src/rfpt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rfpt_datapath (
   input  wire logic                 clock,
   input  wire logic                 adv,
   input  wire rfpt_pkg::ucode_type  s1_ctl,
   input  wire rfpt_pkg::ucode_type  s2_ctl,
   input  wire logic                 s2_valid,
   input  wire rfpt_pkg::word_type   rd_a,
   input  wire rfpt_pkg::word_type   rd_b,
   output rfpt_pkg::word_type        s2_value
);
   import rfpt_pkg::*;

   prod_type prod_ff;
   prod_type prod_in;
   word_type opa_ff;
   word_type acc_ff;
   word_type scr_ff [NUM_SCR];
   word_type op_b;
   word_type term;

   // Stage one: one signed multiply, registered before any further use.
   assign op_b    = s1_ctl.b_scr ? scr_ff[s1_ctl.scr] : rd_b;
   assign prod_in = PROD_W'(rd_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         opa_ff  <= rd_a;
      end
   end

   // Stage two: scale the product (or take operand a for a pass step) and merge it with the accumulator.
   assign term = (s2_ctl.op == OP_MUL) ? sat_prod(prod_ff) : opa_ff;

   always_comb begin
      case (s2_ctl.mode)
         ACC_LOAD: s2_value = term;
         ACC_ADD:  s2_value = sat_add(acc_ff, term);
         ACC_SUB:  s2_value = sat_sub(acc_ff, term);
         default:  s2_value = term;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv && s2_valid) begin
         acc_ff <= s2_value;
         if (s2_ctl.wr_scr) begin
            scr_ff[s2_ctl.scr] <= s2_value;
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/relative_frame_pose_twist_core.sv =====
// Relative frame pose and twist core.
//
// Input channel (req_*): each transfer carries one item. A load item writes
// one Q16.16 element into the 36-entry element store; an index above 35 is
// ignored. A compute item starts the microprogram, which emits 18 result
// transfers on the rsp_* channel in index order, the final one flagged by
// last: nine local rotation terms, three local translation terms and six
// local twist terms.
// Pacing: the microprogram has 84 steps, one issued per cycle while the
// output register can take a result, into a three-stage datapath (store
// read, multiply, scale and accumulate) whose single multiplier sets the
// pace. Without back-pressure the next item is taken in the same cycle in
// which the last result is presented.
// While a compute runs, req_ready is low.
// Back-pressure: the result sits in an output register; while it is held and
// rsp_ready is low the whole sequencer freezes, so nothing is lost and the
// run simply stretches by the stalled cycles. Items are still taken while a
// finished result waits, once the sequencer is idle.
// Reset: synchronous and active high. It clears the store (every element
// reads as zero), stops any run in progress and drops rsp_valid.

`timescale 1ns / 1ps
`default_nettype none

module relative_frame_pose_twist_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire rfpt_pkg::req_type  req_payload,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rfpt_pkg::rsp_type       rsp_payload
);
   import rfpt_pkg::*;

   // Sequencer state.
   logic             run_ff;
   logic             run_in;
   logic [UPC_W-1:0] upc_ff;
   logic [UPC_W-1:0] upc_in;

   // Pipeline occupancy and the control words travelling with each step.
   logic      v1_ff;
   logic      v1_in;
   logic      v2_ff;
   logic      v2_in;
   ucode_type ctl0;
   ucode_type ctl1_ff;
   ucode_type ctl1_in;
   ucode_type ctl2_ff;
   ucode_type ctl2_in;

   // Result numbering and the output register.
   logic [RES_IDX_W-1:0] cnt_ff;
   logic [RES_IDX_W-1:0] cnt_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;

   logic     adv;
   logic     req_xfer;
   logic     start;
   logic     load_en;
   logic     emit_now;
   logic     last_now;
   word_type rd_a;
   word_type rd_b;
   word_type s2_value;

   // The sequencer advances whenever the output register can take a result,
   // so a stalled receiver freezes every stage together.
   assign adv      = !rsp_valid_ff || rsp_ready;
   assign req_ready = !(run_ff || v1_ff || v2_ff);
   assign req_xfer = req_valid && req_ready;
   assign start    = req_xfer && (req_payload.opcode == OP_COMPUTE);
   assign load_en  = req_xfer && (req_payload.opcode == OP_LOAD)
                     && (req_payload.element_index < IDX_W'(NUM_ELEM));

   assign ctl0     = ucode_word(upc_ff);
   assign emit_now = adv && v2_ff && ctl2_ff.emit;
   assign last_now = (cnt_ff == RES_IDX_W'(NUM_RES - 1));

   always_comb begin
      run_in = run_ff;
      upc_in = upc_ff;
      if (start) begin
         run_in = 1'b1;
         upc_in = '0;
      end else if (adv && run_ff) begin
         upc_in = upc_ff + UPC_W'(1);
         if (ctl0.halt) begin
            run_in = 1'b0;
         end
      end
   end

   assign v1_in   = adv ? run_ff  : v1_ff;
   assign v2_in   = adv ? v1_ff   : v2_ff;
   assign ctl1_in = adv ? ctl0    : ctl1_ff;
   assign ctl2_in = adv ? ctl1_ff : ctl2_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (start) begin
         cnt_in = '0;
      end else if (emit_now) begin
         cnt_in = cnt_ff + RES_IDX_W'(1);
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit_now) begin
         rsp_in.result_index = cnt_ff;
         rsp_in.result_value = OUT_VAL_W'(s2_value);
         rsp_in.last         = last_now;
         rsp_valid_in        = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         upc_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         upc_ff       <= upc_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctl1_ff <= ctl1_in;
      ctl2_ff <= ctl2_in;
      rsp_ff  <= rsp_in;
   end

   // Element store: written by load transfers, read at the two addresses of
   // the microcode word in the first pipeline stage.
   rfpt_store u_store (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (load_en),
      .wr_addr   (req_payload.element_index[ELEM_AW-1:0]),
      .wr_data   (load_word(req_payload.element_value)),
      .rd_en     (adv),
      .rd_addr_a (ctl0.addr_a),
      .rd_addr_b (ctl0.addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   rfpt_datapath u_datapath (
      .clock    (clock),
      .adv      (adv),
      .s1_ctl   (ctl1_ff),
      .s2_ctl   (ctl2_ff),
      .s2_valid (v2_ff),
      .rd_a     (rd_a),
      .rd_b     (rd_b),
      .s2_value (s2_value)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // No more than eighteen results are numbered in one run.
   a_res_count : assert property (@(posedge clock) disable iff (reset)
      (v2_ff && ctl2_ff.emit) |-> (cnt_ff < RES_IDX_W'(NUM_RES)))
      else $error("result counter overran during a compute run");

   // A run only ends by issuing the halting microcode word.
   a_halt_word : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(run_ff)) |-> (v1_ff && ctl1_ff.halt))
      else $error("sequencer stopped without a halting step");

   // Once the final result is committed the sequencer is empty.
   a_drain : assert property (@(posedge clock) disable iff (reset)
      (emit_now && last_now) |=> !(run_ff || v1_ff || v2_ff))
      else $error("steps still in flight after the final result");

endmodule

`default_nettype wire

// ===== tb/tb_relative_frame_pose_twist_core.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the relative frame pose and twist core.
//
// Every item that the block takes on the request channel is also applied to
// a local model of the element store held in this module. A compute transfer
// there expands into the eighteen results that the block must return: nine
// rotation terms, three translation terms and six twist terms, the final one
// carrying last. These wait in a queue, and a checker process compares every
// result transfer, field by field, with the oldest one waiting.
//
// The stimulus opens with a short directed part that walks the saturation
// corners of products, sums and differences. Random pose sets follow, with
// loads to random elements and then a compute. Most of the values are plausible
// Q16.16 magnitudes, with extremes and raw words mixed in. Each random phase
// idles the two sides in a different mix. In one phase the receiver holds off
// for a long stretch, so that the core freezes mid-run and stalls its input.

module tb_relative_frame_pose_twist_core;

   import rfpt_pkg::*;

   // Word range as 64-bit integers, so that the model never overflows.
   localparam longint W_HI = (longint'(1) <<< (WORD_W - 1)) - 1;
   localparam longint W_LO = -W_HI - 1;

   localparam logic signed [IN_VAL_W-1:0] V_MAX = {1'b0, {(IN_VAL_W-1){1'b1}}};
   localparam logic signed [IN_VAL_W-1:0] V_MIN = {1'b1, {(IN_VAL_W-1){1'b0}}};
   localparam logic signed [IN_VAL_W-1:0] V_ONE = IN_VAL_W'(1) <<< FRAC_BITS;
   localparam logic signed [IN_VAL_W-1:0] V_NEG_TINY = '1;

   // This comfortably covers any work still in flight once the final result has been seen.
   localparam int DRAIN_CYCLES = 120;
   localparam int HOLD_CYCLES  = 400;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // Local copy of the element store, and the results still owed by the core.
   longint  frame_elems[NUM_ELEM] = '{default: 0};
   rsp_type pending_results[$];
   rsp_type oldest_result;

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   logic hold_rsp    = 1'b0;

   int n_mismatch        = 0;
   int n_loads_sent      = 0;
   int n_computes_sent   = 0;
   int n_results_checked = 0;

   relative_frame_pose_twist_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Fixed-point arithmetic of the model
   // ---------------------------------------------------------------------

   function automatic longint fit_word(longint v);
      if (v > W_HI) begin
         return W_HI;
      end
      if (v < W_LO) begin
         return W_LO;
      end
      return v;
   endfunction

   function automatic longint add_sat(longint a, longint b);
      return fit_word(a + b);
   endfunction

   function automatic longint sub_sat(longint a, longint b);
      return fit_word(a - b);
   endfunction

   // Full-width product, scaled back by an arithmetic shift (so the fraction
   // is truncated towards minus infinity), then clamped to the word.
   function automatic longint mul_q(longint a, longint b);
      longint p;
      p = a * b;
      return fit_word(p >>> FRAC_BITS);
   endfunction

   // One row of the transposed flexible rotation applied to a column vector.
   // Rf^T row r is column r of Rf, accumulated in the order 0, 1, 2.
   function automatic longint rot_t_row(int r, longint x0, longint x1, longint x2);
      longint acc;
      acc = mul_q(frame_elems[E_RF + r], x0);
      acc = add_sat(acc, mul_q(frame_elems[E_RF + 3 + r], x1));
      return add_sat(acc, mul_q(frame_elems[E_RF + 6 + r], x2));
   endfunction

   // Applies one accepted request to the model store and, for a compute,
   // queues the eighteen results in the order that the core emits them.
   function automatic void predict_transfer(req_type item);
      longint  res[NUM_RES];
      longint  xv[3];
      longint  dv[3];
      longint  cr[3];
      rsp_type r;
      int      i;
      int      j;
      if (item.opcode == OP_LOAD) begin
         n_loads_sent++;
         // An index beyond the store is dropped without any effect.
         if (item.element_index < NUM_ELEM) begin
            frame_elems[item.element_index] = fit_word(longint'($signed(item.element_value)));
         end
         return;
      end
      n_computes_sent++;

      // Local rotation Rf^T * Rg, row-major, one column of Rg at a time.
      for (j = 0; j < 3; j++) begin
         for (i = 0; i < 3; i++) begin
            res[3 * i + j] = rot_t_row(i, frame_elems[E_RG + j], frame_elems[E_RG + 3 + j],
                                       frame_elems[E_RG + 6 + j]);
         end
      end

      // Local translation Rf^T * (tg - tf).
      for (i = 0; i < 3; i++) begin
         xv[i] = sub_sat(frame_elems[E_TG + i], frame_elems[E_TF + i]);
      end
      for (i = 0; i < 3; i++) begin
         res[9 + i] = rot_t_row(i, xv[0], xv[1], xv[2]);
      end

      // Linear twist: Rf^T * ((wf x (tf - tg) + vg) - vf).
      for (i = 0; i < 3; i++) begin
         dv[i] = sub_sat(frame_elems[E_TF + i], frame_elems[E_TG + i]);
      end
      cr[0] = sub_sat(mul_q(frame_elems[E_WF + 1], dv[2]), mul_q(frame_elems[E_WF + 2], dv[1]));
      cr[1] = sub_sat(mul_q(frame_elems[E_WF + 2], dv[0]), mul_q(frame_elems[E_WF + 0], dv[2]));
      cr[2] = sub_sat(mul_q(frame_elems[E_WF + 0], dv[1]), mul_q(frame_elems[E_WF + 1], dv[0]));
      for (i = 0; i < 3; i++) begin
         xv[i] = sub_sat(add_sat(cr[i], frame_elems[E_VG + i]), frame_elems[E_VF + i]);
      end
      for (i = 0; i < 3; i++) begin
         res[12 + i] = rot_t_row(i, xv[0], xv[1], xv[2]);
      end

      // Angular twist: Rf^T * (wg - wf).
      for (i = 0; i < 3; i++) begin
         xv[i] = sub_sat(frame_elems[E_WG + i], frame_elems[E_WF + i]);
      end
      for (i = 0; i < 3; i++) begin
         res[15 + i] = rot_t_row(i, xv[0], xv[1], xv[2]);
      end

      for (i = 0; i < NUM_RES; i++) begin
         r.result_index = RES_IDX_W'(i);
         r.result_value = OUT_VAL_W'(res[i]);
         r.last         = (i == NUM_RES - 1);
         pending_results.push_back(r);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offers one item and returns at the edge on which it was transferred.
   // Valid is deliberately left high afterwards: the next call either keeps
   // it high with a new payload in the same step, or lowers it for a gap.
   // While idle the payload carries noise, which the core must ignore.
   task automatic send_item(logic op, logic [IDX_W-1:0] idx, logic [IN_VAL_W-1:0] val);
      req_type item;
      item.opcode        = op;
      item.element_index = idx;
      item.element_value = val;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid   <= 1'b0;
         req_payload <= {1'($urandom), IDX_W'($urandom), IN_VAL_W'($urandom)};
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      predict_transfer(item);
   endtask

   // Random element value: mostly plausible magnitudes within four units,
   // with the word limits, tiny fractions and raw words mixed in.
   function automatic logic signed [IN_VAL_W-1:0] rand_q();
      case ($urandom_range(15))
         0: return V_MAX;
         1: return V_MIN;
         2, 3: return IN_VAL_W'($urandom);
         4: return IN_VAL_W'($signed($urandom_range(0, 510)) - 255);
         default: return IN_VAL_W'($signed($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------

   // Ready is redrawn every cycle, and forced low while a hold-off runs.
   always @(posedge clock) begin
      rsp_ready <= !hold_rsp && ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            n_mismatch++;
            $display("%0t ns: result transfer with none expected: index %0d value %0d last %0b",
                     $time, rsp_payload.result_index, rsp_payload.result_value,
                     rsp_payload.last);
         end else begin
            oldest_result = pending_results.pop_front();
            n_results_checked++;
            if (rsp_payload.result_index !== oldest_result.result_index ||
                rsp_payload.result_value !== oldest_result.result_value ||
                rsp_payload.last !== oldest_result.last) begin
               n_mismatch++;
               $display("%0t ns: expected index %0d value %0d last %0b, got index %0d value %0d last %0b",
                        $time, oldest_result.result_index, oldest_result.result_value,
                        oldest_result.last, rsp_payload.result_index, rsp_payload.result_value,
                        rsp_payload.last);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Corners of the arithmetic. A compute on the cleared store must give all
   // zeros. Products of the word limits saturate, and two saturated products
   // summed saturate again. Opposite extremes make both translation
   // differences saturate. A small negative angular rate is loaded into wf.
   // Out-of-range loads must leave the store alone, and a repeated compute
   // must find the store as it was.
   task automatic test_corner_cases();
      send_item(OP_COMPUTE, '0, '0);
      send_item(OP_LOAD, IDX_W'(E_RF + 0), V_MAX);
      send_item(OP_LOAD, IDX_W'(E_RF + 3), V_MAX);
      send_item(OP_LOAD, IDX_W'(E_RG + 0), V_MIN);
      send_item(OP_LOAD, IDX_W'(E_RG + 1), V_MAX);
      send_item(OP_LOAD, IDX_W'(E_RG + 4), V_MAX);
      send_item(OP_LOAD, '1, 32'h0000_1234);
      send_item(OP_LOAD, IDX_W'(NUM_ELEM), V_MAX);
      send_item(OP_LOAD, IDX_W'(E_TF + 0), V_MIN);
      send_item(OP_LOAD, IDX_W'(E_TG + 0), V_MAX);
      send_item(OP_LOAD, IDX_W'(E_WF + 0), V_NEG_TINY);
      send_item(OP_LOAD, IDX_W'(E_WF + 1), V_ONE);
      send_item(OP_LOAD, IDX_W'(E_WF + 2), -(V_ONE >>> 1));
      send_item(OP_LOAD, IDX_W'(E_VG + 0), V_MAX);
      send_item(OP_LOAD, IDX_W'(E_VF + 0), V_MIN);
      send_item(OP_LOAD, IDX_W'(E_WG + 0), V_MIN);
      send_item(OP_COMPUTE, '0, '0);
      send_item(OP_COMPUTE, '1, '1);
   endtask

   // Well-formed pose sets: a handful of loads and then a compute. About one
   // set in ten is noise instead, with random opcodes and indexes.
   task automatic test_random_pose_sets(int n_items, int s_idle, int r_idle);
      int sent;
      int n_set;
      int idx;
      send_idle_pct = s_idle;
      rsp_idle_pct <= r_idle;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(9) == 0) begin
            n_set = $urandom_range(1, 4);
            repeat (n_set) begin
               send_item(1'($urandom), IDX_W'($urandom), IN_VAL_W'($urandom));
               sent++;
            end
         end else begin
            n_set = $urandom_range(2, 14);
            repeat (n_set) begin
               idx = ($urandom_range(15) == 0) ? $urandom_range(NUM_ELEM, 63)
                                               : $urandom_range(NUM_ELEM - 1);
               send_item(OP_LOAD, IDX_W'(idx), rand_q());
               sent++;
            end
            send_item(OP_COMPUTE, IDX_W'($urandom), IN_VAL_W'($urandom));
            sent++;
         end
      end
   endtask

   // The receiver refuses results for a long stretch while the sender keeps
   // offering. A result is stuck in the output register, the sequencer freezes
   // and the request channel stays blocked until the hold-off ends.
   task automatic test_output_hold();
      int i;
      send_idle_pct = 0;
      rsp_idle_pct <= 0;
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         begin
            for (i = 0; i < 8; i++) begin
               send_item(OP_LOAD, IDX_W'($urandom_range(NUM_ELEM - 1)), rand_q());
            end
            send_item(OP_COMPUTE, '0, '0);
            for (i = 0; i < 6; i++) begin
               send_item(OP_LOAD, IDX_W'($urandom_range(NUM_ELEM - 1)), rand_q());
            end
            send_item(OP_COMPUTE, '0, '0);
            for (i = 0; i < 4; i++) begin
               send_item(OP_LOAD, IDX_W'($urandom_range(NUM_ELEM - 1)), rand_q());
            end
         end
      join
   endtask

   // Stops offering, waits for every owed result, then lets the core settle.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_cases();
      test_random_pose_sets(70, 10, 50);
      test_random_pose_sets(70, 50, 10);
      test_output_hold();
      test_random_pose_sets(70, 0, 0);
      wait_for_drain();

      $display("Sent %0d loads and %0d computes; checked %0d results.",
               n_loads_sent, n_computes_sent, n_results_checked);
      $display("Covered saturation corners, three idling mixes and a long output hold-off.");
      if (n_mismatch == 0) begin
         $display("relative_frame_pose_twist_core: match");
      end else begin
         $display("relative_frame_pose_twist_core: mismatch");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("Timed out with %0d results still owed.", pending_results.size());
      $display("relative_frame_pose_twist_core: mismatch");
      $finish;
   end

endmodule

// ===== relative_frame_pose_twist_core.f =====
src/rfpt_pkg.sv
src/rfpt_store.sv
src/rfpt_datapath.sv
src/relative_frame_pose_twist_core.sv
tb/tb_relative_frame_pose_twist_core.sv
